// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define FKT_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define FKT_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/fkt_pkg.sv =====
// ----------------------------------------------------------------------------
// fkt_pkg
// Types and constants of the flow key table.
// ----------------------------------------------------------------------------
package fkt_pkg;

   localparam int MAX_BUCKETS      = 1024;
   localparam int SLOTS_PER_BUCKET = 8;
   localparam int KEY_W            = 104;
   localparam int BUCKET_W         = 10;
   localparam int SLOT_W           = 3;
   localparam int FILL_W           = 4;
   localparam int ENTRY_ADDR_W     = BUCKET_W + SLOT_W;
   localparam int ENTRY_W          = KEY_W + 32 + 64;
   localparam int COUNT_W          = 14;
   localparam int CSR_INDEX_W      = 3;

   localparam logic [1:0] REQ_RECORD = 2'd0;
   localparam logic [1:0] REQ_FIND   = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;

   localparam logic [2:0] ST_HIT       = 3'd0;
   localparam logic [2:0] ST_INSERTED  = 3'd1;
   localparam logic [2:0] ST_REPLACED  = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;
   localparam logic [2:0] ST_CLEARED   = 3'd5;

   localparam logic [CSR_INDEX_W-1:0] CSR_BUCKET_COUNT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDLE_TIMEOUT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPIRY_ENABLE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HASH_INIT     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HASH_SCALE    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_HASH_HARDENER = 3'd5;

   typedef struct packed {
      logic [63:0] init;
      logic [63:0] scale;
      logic [63:0] hardener;
      logic [10:0] bucket_count;
   } fkt_hash_cfg_type;

   typedef struct packed {
      logic                record;
      logic [KEY_W-1:0]    key;
      logic [31:0]         timestamp;
      logic [31:0]         add_amount;
      logic [BUCKET_W-1:0] bucket;
   } fkt_job_type;

   typedef struct packed {
      logic start;
      logic clear;
   } fkt_tbl_cmd_type;

   typedef struct packed {
      logic [2:0]          status;
      logic [BUCKET_W-1:0] bucket_index;
      logic [SLOT_W-1:0]   slot_index;
      logic [31:0]         prev_timestamp;
      logic [63:0]         byte_total;
      logic [COUNT_W-1:0]  key_count;
   } fkt_rsp_type;

endpackage

// ===== design/fkt_hash.sv =====
// ----------------------------------------------------------------------------
// fkt_hash
// Multiply-add key hash over a shared 32x32 multiplier, then a bit-serial
// reduction modulo the bucket count.
// ----------------------------------------------------------------------------
module fkt_hash #(
   parameter int KEY_BYTES = 13
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [fkt_pkg::KEY_W-1:0]   key,
   input  fkt_pkg::fkt_hash_cfg_type   cfg,
   output logic                        done,
   output logic [fkt_pkg::BUCKET_W-1:0] bucket
);
   import fkt_pkg::*;

   localparam int BYTE_W = $clog2(KEY_BYTES);
   localparam int STORED_BYTES = KEY_W / 8;

   typedef enum logic [5:0] {
      H_IDLE = 6'b000001,
      H_MUL0 = 6'b000010,
      H_MUL1 = 6'b000100,
      H_MUL2 = 6'b001000,
      H_MOD  = 6'b010000,
      H_DONE = 6'b100000
   } hash_state_type;

   hash_state_type state_ff, state_in;
   logic [63:0]         h_ff;
   logic [63:0]         acc_ff;
   logic [63:0]         num_ff;
   logic [BYTE_W-1:0]   byte_ff;
   logic [BUCKET_W-1:0] rem_ff;
   logic [5:0]          bit_ff;

   logic [7:0]  key_bytes [KEY_BYTES];
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] prod;
   logic [63:0] h_next;
   logic [10:0] nb;
   logic [10:0] trial;
   logic        last_byte;

   genvar gj;
   generate
      for (gj = 0; gj < KEY_BYTES; gj++) begin : g_bytes
         if (gj < STORED_BYTES) begin : g_key
            assign key_bytes[gj] = key[8*gj +: 8];
         end else begin : g_pad
            assign key_bytes[gj] = 8'd0;
         end
      end
   endgenerate

   always_comb begin
      if (cfg.bucket_count == 11'd0) begin
         nb = 11'd1;
      end else if (cfg.bucket_count > 11'(MAX_BUCKETS)) begin
         nb = 11'(MAX_BUCKETS);
      end else begin
         nb = cfg.bucket_count;
      end
   end

   assign mul_a     = (state_ff == H_MUL2) ? h_ff[63:32] : h_ff[31:0];
   assign mul_b     = (state_ff == H_MUL1) ? cfg.scale[63:32] : cfg.scale[31:0];
   assign prod      = {32'd0, mul_a} * {32'd0, mul_b};
   assign h_next    = {acc_ff[63:32] + prod[31:0], acc_ff[31:0]};
   assign last_byte = (byte_ff == BYTE_W'(KEY_BYTES - 1));
   assign trial     = {rem_ff, num_ff[63]};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         H_IDLE:  if (start) state_in = H_MUL0;
         H_MUL0:  state_in = H_MUL1;
         H_MUL1:  state_in = H_MUL2;
         H_MUL2:  state_in = last_byte ? H_MOD : H_MUL0;
         H_MOD:   if (bit_ff == 6'd63) state_in = H_DONE;
         H_DONE:  state_in = H_IDLE;
         default: state_in = H_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         H_IDLE: begin
            h_ff    <= cfg.init;
            byte_ff <= '0;
         end
         H_MUL0: begin
            acc_ff <= prod + {56'd0, key_bytes[byte_ff]};
         end
         H_MUL1: begin
            acc_ff[63:32] <= acc_ff[63:32] + prod[31:0];
         end
         H_MUL2: begin
            h_ff    <= h_next;
            num_ff  <= h_next ^ cfg.hardener;
            byte_ff <= byte_ff + BYTE_W'(1);
            rem_ff  <= '0;
            bit_ff  <= '0;
         end
         H_MOD: begin
            // one quotient bit per cycle, restoring form
            num_ff <= {num_ff[62:0], 1'b0};
            rem_ff <= (trial >= nb) ? BUCKET_W'(trial - nb) : trial[BUCKET_W-1:0];
            bit_ff <= bit_ff + 6'd1;
         end
         default: begin
         end
      endcase
   end

   assign done   = (state_ff == H_DONE);
   assign bucket = rem_ff;

endmodule

// ===== design/fkt_table.sv =====
// ----------------------------------------------------------------------------
// fkt_table
// Bucket fill memory and entry memory, slot scan, update and clear sweep.
// ----------------------------------------------------------------------------
module fkt_table #(
   parameter int KEY_BYTES = 13
) (
   input  logic                      clock,
   input  logic                      reset,
   input  fkt_pkg::fkt_tbl_cmd_type  cmd,
   input  fkt_pkg::fkt_job_type      job,
   input  logic [31:0]               idle_timeout,
   input  logic                      expiry_enable,
   input  logic                      out_free,
   output logic                      ready,
   output logic                      done,
   output fkt_pkg::fkt_rsp_type      rsp
);
   import fkt_pkg::*;

   localparam int STORED_BYTES = KEY_W / 8;

   typedef enum logic [6:0] {
      T_SWEEP  = 7'b0000001,
      T_IDLE   = 7'b0000010,
      T_FILL   = 7'b0000100,
      T_READ   = 7'b0001000,
      T_CHECK  = 7'b0010000,
      T_DECIDE = 7'b0100000,
      T_DONE   = 7'b1000000
   } tbl_state_type;

   logic [FILL_W-1:0]  fill_mem  [MAX_BUCKETS];
   logic [ENTRY_W-1:0] entry_mem [MAX_BUCKETS*SLOTS_PER_BUCKET];

   tbl_state_type state_ff, state_in;
   logic [BUCKET_W-1:0] sweep_ff;
   logic                report_ff;
   fkt_job_type         job_ff;
   logic [FILL_W-1:0]   fill_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic                hit_ff;
   logic [SLOT_W-1:0]   hit_slot_ff;
   logic                idle_ff;
   logic [SLOT_W-1:0]   idle_slot_ff;
   logic [31:0]         old_time_ff;
   logic [63:0]         old_bytes_ff;
   logic [COUNT_W-1:0]  appended_ff;
   fkt_rsp_type         rsp_ff;
   logic [FILL_W-1:0]   fill_q;
   logic [ENTRY_W-1:0]  ent_q;

   logic [KEY_W-1:0]    ent_key;
   logic [31:0]         ent_time;
   logic [63:0]         ent_bytes;
   logic                key_match;
   logic                slot_idle;
   logic                scan_last;
   logic                sweep_last;

   // decision of one request
   fkt_rsp_type         dec_rsp;
   logic                ent_we;
   logic                fill_we;
   logic [COUNT_W-1:0]  appended_in;
   logic [BUCKET_W-1:0] fill_waddr;
   logic [FILL_W-1:0]   fill_wdata;
   logic                fill_wen;

   assign ent_key   = ent_q[ENTRY_W-1 -: KEY_W];
   assign ent_time  = ent_q[95:64];
   assign ent_bytes = ent_q[63:0];

   always_comb begin
      key_match = 1'b1;
      for (int j = 0; j < STORED_BYTES; j++) begin
         if (j < KEY_BYTES && ent_key[8*j +: 8] != job_ff.key[8*j +: 8]) begin
            key_match = 1'b0;
         end
      end
   end

   assign slot_idle  = expiry_enable && (job_ff.timestamp >= ent_time) &&
                       ((job_ff.timestamp - ent_time) > idle_timeout);
   assign scan_last  = (({1'b0, slot_ff} + FILL_W'(1)) == fill_ff);
   assign sweep_last = (sweep_ff == BUCKET_W'(MAX_BUCKETS - 1));

   always_comb begin
      dec_rsp              = '0;
      dec_rsp.bucket_index = job_ff.bucket;
      dec_rsp.key_count    = appended_ff;
      ent_we               = 1'b0;
      fill_we              = 1'b0;
      appended_in          = appended_ff;
      if (!job_ff.record) begin
         if (hit_ff) begin
            dec_rsp.status         = ST_HIT;
            dec_rsp.slot_index     = hit_slot_ff;
            dec_rsp.prev_timestamp = old_time_ff;
            dec_rsp.byte_total     = old_bytes_ff;
         end else begin
            dec_rsp.status = ST_NOT_FOUND;
         end
      end else if (hit_ff) begin
         dec_rsp.status         = ST_HIT;
         dec_rsp.slot_index     = hit_slot_ff;
         dec_rsp.prev_timestamp = old_time_ff;
         dec_rsp.byte_total     = ((old_time_ff == 32'd0) ? 64'd0 : old_bytes_ff) +
                                  {32'd0, job_ff.add_amount};
         ent_we                 = 1'b1;
      end else if (idle_ff) begin
         dec_rsp.status     = ST_REPLACED;
         dec_rsp.slot_index = idle_slot_ff;
         dec_rsp.byte_total = {32'd0, job_ff.add_amount};
         ent_we             = 1'b1;
      end else if (fill_ff >= FILL_W'(SLOTS_PER_BUCKET)) begin
         dec_rsp.status = ST_FULL;
      end else begin
         dec_rsp.status     = ST_INSERTED;
         dec_rsp.slot_index = fill_ff[SLOT_W-1:0];
         dec_rsp.byte_total = {32'd0, job_ff.add_amount};
         ent_we             = 1'b1;
         fill_we            = 1'b1;
         appended_in        = appended_ff + COUNT_W'(1);
         dec_rsp.key_count  = appended_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         T_SWEEP: begin
            if (sweep_last) state_in = report_ff ? T_DONE : T_IDLE;
         end
         T_IDLE: begin
            if (cmd.start) state_in = cmd.clear ? T_SWEEP : T_FILL;
         end
         T_FILL:   state_in = (fill_q == '0) ? T_DECIDE : T_READ;
         T_READ:   state_in = T_CHECK;
         T_CHECK: begin
            if (key_match || scan_last) begin
               state_in = T_DECIDE;
            end else begin
               state_in = T_READ;
            end
         end
         T_DECIDE: state_in = T_DONE;
         T_DONE:   if (out_free) state_in = T_IDLE;
         default:  state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= T_SWEEP;
         sweep_ff    <= '0;
         report_ff   <= 1'b0;
         appended_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == T_SWEEP) begin
            sweep_ff <= sweep_ff + BUCKET_W'(1);
         end
         if (state_ff == T_IDLE && cmd.start && cmd.clear) begin
            sweep_ff    <= '0;
            report_ff   <= 1'b1;
            appended_ff <= '0;
         end
         if (state_ff == T_DECIDE) begin
            appended_ff <= appended_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         T_SWEEP: begin
            rsp_ff <= '{status: ST_CLEARED, default: '0};
         end
         T_IDLE: begin
            job_ff <= job;
         end
         T_FILL: begin
            fill_ff <= fill_q;
            slot_ff <= '0;
            hit_ff  <= 1'b0;
            idle_ff <= 1'b0;
         end
         T_CHECK: begin
            if (key_match) begin
               hit_ff       <= 1'b1;
               hit_slot_ff  <= slot_ff;
               old_time_ff  <= ent_time;
               old_bytes_ff <= ent_bytes;
            end else begin
               if (slot_idle && !idle_ff) begin
                  idle_ff      <= 1'b1;
                  idle_slot_ff <= slot_ff;
               end
               slot_ff <= slot_ff + SLOT_W'(1);
            end
         end
         T_DECIDE: begin
            rsp_ff <= dec_rsp;
         end
         default: begin
         end
      endcase
   end

   // fill memory: read on request start, write on insert or sweep
   assign fill_wen   = (state_ff == T_SWEEP) || (state_ff == T_DECIDE && fill_we);
   assign fill_waddr = (state_ff == T_SWEEP) ? sweep_ff : job_ff.bucket;
   assign fill_wdata = (state_ff == T_SWEEP) ? '0 : fill_ff + FILL_W'(1);

   always_ff @(posedge clock) begin
      if (fill_wen) begin
         fill_mem[fill_waddr] <= fill_wdata;
      end
      if (state_ff == T_IDLE && cmd.start) begin
         fill_q <= fill_mem[job.bucket];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == T_DECIDE && ent_we) begin
         entry_mem[{job_ff.bucket, dec_rsp.slot_index}] <=
            {job_ff.key, job_ff.timestamp, dec_rsp.byte_total};
      end
      if (state_ff == T_READ) begin
         ent_q <= entry_mem[{job_ff.bucket, slot_ff}];
      end
   end

   assign ready = (state_ff == T_IDLE);
   assign done  = (state_ff == T_DONE) && out_free;
   assign rsp   = rsp_ff;

endmodule

// ===== design/flow_key_table_top.sv =====
// ----------------------------------------------------------------------------
// flow_key_table_top
// Bucketed flow table keyed by the 5-tuple, with idle-slot replacement.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  req_      in         req_valid / req_stall  type, 5-tuple, timestamp, amount
//  rsp_      out        rsp_valid / rsp_stall  status, bucket, slot, time, bytes, count
//  csr_      in         csr_valid / csr_ready  csr_index, csr_data
//
//  Hash: states MUL0, MUL1 and MUL2 for each key byte on one shared 32x32
//  multiplier, then bit-serial modulo; slot scan: a read and a check per
//  filled slot. After reset and on each clear the fill memory is swept.
//  A finished result waits in the output register while the next item runs.
// ----------------------------------------------------------------------------
module flow_key_table_top #(
   parameter int KEY_BYTES = 13
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_source_ip,
   input  logic [31:0] req_dest_ip,
   input  logic [15:0] req_source_port,
   input  logic [15:0] req_dest_port,
   input  logic [7:0]  req_protocol,
   input  logic [31:0] req_timestamp,
   input  logic [31:0] req_add_amount,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [9:0]  rsp_bucket_index,
   output logic [2:0]  rsp_slot_index,
   output logic [31:0] rsp_prev_timestamp,
   output logic [63:0] rsp_byte_total,
   output logic [13:0] rsp_key_count,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [fkt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0] csr_data
);
   import fkt_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_LAUNCH = 4'b0010,
      S_HASH   = 4'b0100,
      S_TABLE  = 4'b1000
   } top_state_type;

   top_state_type state_ff, state_in;

   logic [10:0]      bucket_count_ff;
   logic [31:0]      idle_timeout_ff;
   logic             expiry_enable_ff;
   logic [63:0]      hash_init_ff;
   logic [63:0]      hash_scale_ff;
   logic [63:0]      hash_hardener_ff;

   logic [1:0]       type_ff;
   logic [KEY_W-1:0] key_ff;
   logic [31:0]      ts_ff;
   logic [31:0]      add_ff;

   logic             rsp_valid_ff;
   fkt_rsp_type      rsp_ff;

   logic             req_xfer;
   logic             clear_req;
   logic             hash_start;
   logic             hash_done;
   logic [BUCKET_W-1:0] hash_bucket;
   fkt_hash_cfg_type hash_cfg;
   fkt_tbl_cmd_type  tbl_cmd;
   fkt_job_type      tbl_job;
   logic             tbl_ready;
   logic             tbl_done;
   fkt_rsp_type      tbl_rsp;
   logic             out_free;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff  <= 11'd1021;
         idle_timeout_ff  <= '0;
         expiry_enable_ff <= 1'b0;
         hash_init_ff     <= '0;
         hash_scale_ff    <= 64'd1;
         hash_hardener_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BUCKET_COUNT:  bucket_count_ff  <= csr_data[10:0];
            CSR_IDLE_TIMEOUT:  idle_timeout_ff  <= csr_data[31:0];
            CSR_EXPIRY_ENABLE: expiry_enable_ff <= csr_data[0];
            CSR_HASH_INIT:     hash_init_ff     <= csr_data;
            CSR_HASH_SCALE:    hash_scale_ff    <= csr_data;
            CSR_HASH_HARDENER: hash_hardener_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign req_stall = !((state_ff == S_IDLE) && tbl_ready);
   assign req_xfer  = req_valid && !req_stall;
   assign clear_req = (type_ff == REQ_CLEAR);

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         type_ff <= req_type;
         key_ff  <= {req_protocol, req_dest_port, req_source_port,
                     req_dest_ip, req_source_ip};
         ts_ff   <= req_timestamp;
         add_ff  <= req_add_amount;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_xfer) state_in = S_LAUNCH;
         S_LAUNCH: state_in = clear_req ? S_TABLE : S_HASH;
         S_HASH:   if (hash_done) state_in = S_TABLE;
         S_TABLE:  if (tbl_done) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign hash_start = (state_ff == S_LAUNCH) && !clear_req;
   assign hash_cfg   = '{init: hash_init_ff, scale: hash_scale_ff,
                         hardener: hash_hardener_ff, bucket_count: bucket_count_ff};

   fkt_hash #(
      .KEY_BYTES (KEY_BYTES)
   ) u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (hash_start),
      .key    (key_ff),
      .cfg    (hash_cfg),
      .done   (hash_done),
      .bucket (hash_bucket)
   );

   assign tbl_cmd.start = ((state_ff == S_LAUNCH) && clear_req) ||
                          ((state_ff == S_HASH) && hash_done);
   assign tbl_cmd.clear = (state_ff == S_LAUNCH) && clear_req;
   assign tbl_job       = '{record: (type_ff == REQ_RECORD), key: key_ff,
                            timestamp: ts_ff, add_amount: add_ff, bucket: hash_bucket};
   assign out_free      = !rsp_valid_ff || !rsp_stall;

   fkt_table #(
      .KEY_BYTES (KEY_BYTES)
   ) u_table (
      .clock         (clock),
      .reset         (reset),
      .cmd           (tbl_cmd),
      .job           (tbl_job),
      .idle_timeout  (idle_timeout_ff),
      .expiry_enable (expiry_enable_ff),
      .out_free      (out_free),
      .ready         (tbl_ready),
      .done          (tbl_done),
      .rsp           (tbl_rsp)
   );

   // output register: load a finished result, drop it after its transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (tbl_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_done) begin
         rsp_ff <= tbl_rsp;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_bucket_index   = rsp_ff.bucket_index;
   assign rsp_slot_index     = rsp_ff.slot_index;
   assign rsp_prev_timestamp = rsp_ff.prev_timestamp;
   assign rsp_byte_total     = rsp_ff.byte_total;
   assign rsp_key_count      = rsp_ff.key_count;

endmodule

// ===== design/fkt_checker.sv =====
// ----------------------------------------------------------------------------
// fkt_checker
// Port-level checks of the flow key table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fkt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic [9:0]  rsp_bucket_index,
   input logic [31:0] rsp_prev_timestamp,
   input logic [63:0] rsp_byte_total,
   input logic [13:0] rsp_key_count
);
   import fkt_pkg::*;

   `FKT_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "stalled result dropped")
   `FKT_ASSERT_IMP(a_status_code, rsp_valid, rsp_status <= ST_CLEARED, "bad status code")
   `FKT_ASSERT_IMP(a_clear_zero, rsp_valid && rsp_status == ST_CLEARED,
      rsp_bucket_index == 10'd0 && rsp_key_count == 14'd0 && rsp_byte_total == 64'd0,
      "clear result not zero")
   `FKT_ASSERT_IMP(a_miss_zero, rsp_valid && rsp_status == ST_NOT_FOUND,
      rsp_prev_timestamp == 32'd0 && rsp_byte_total == 64'd0, "miss result not zero")
   `FKT_ASSERT_NXT(a_one_at_a_time, req_valid && !req_stall, req_stall,
      "second transfer taken while busy")

endmodule

bind flow_key_table_top fkt_checker u_fkt_checker (.*);
